// File: hw/rtl/order_book_matching_engine_defines.svh
// Assertion macros for the order book matching engine.
`ifndef ORDER_BOOK_MATCHING_ENGINE_DEFINES_SVH
`define ORDER_BOOK_MATCHING_ENGINE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define OBME_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define OBME_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/obme_pkg.sv
// Shared types, constants and codes of the order book matching engine.
package obme_pkg;

  localparam int TICKERS_DEF    = 4;
  localparam int BOOK_DEPTH_DEF = 8;
  localparam int MAX_RESULTS    = 64;
  localparam int COMM_DIVISOR   = 100;
  localparam int COMM_MULT      = 2;

  localparam int TKR_W    = 2;
  localparam int CLIENT_W = 8;
  localparam int PRICE_W  = 20;
  localparam int SHARES_W = 16;
  localparam int SEQ_W    = 32;
  localparam int TS_W     = 32;
  localparam int VALUE_W  = 36;
  localparam int COMM_W   = 31;
  localparam int SLOT_W   = 8;
  localparam int CNT_W    = 7;

  localparam logic KIND_EOD     = 1'b1;
  localparam logic SIDE_BUY     = 1'b1;
  localparam logic STAT_TRADE   = 1'b0;
  localparam logic STAT_REJECT  = 1'b1;

  typedef enum logic {OP_BEST, OP_INSERT} probe_op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INS, ST_REJ, ST_LAUNCH, ST_COLLECT, ST_SEL,
    ST_MUL, ST_DSTART, ST_DWAIT, ST_EMIT, ST_FIN
  } state_t;

  typedef struct packed {
    logic                vld;
    probe_op_t           op;
    logic [TKR_W-1:0]    tkr;
    logic                found;
    logic [SLOT_W-1:0]   slot;
    logic [PRICE_W-1:0]  price;
    logic [SHARES_W-1:0] shares;
    logic [SEQ_W-1:0]    seq;
    logic [CLIENT_W-1:0] client;
  } probe_t;

  typedef struct packed {
    logic                vld;
    logic [SLOT_W-1:0]   slot;
    logic [SHARES_W-1:0] qty;
  } upd_t;

  typedef struct packed {
    logic                status;
    logic [TKR_W-1:0]    tkr;
    logic [CLIENT_W-1:0] buyer;
    logic [CLIENT_W-1:0] seller;
    logic [PRICE_W-1:0]  price;
    logic [SHARES_W-1:0] shares;
    logic [VALUE_W-1:0]  value;
    logic [COMM_W-1:0]   comm;
  } result_t;

endpackage

// File: hw/rtl/obme_ifs.sv
// Order and result channel interfaces.
interface obme_in_if import obme_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                kind;
  logic [TS_W-1:0]     timestamp;
  logic                side;
  logic [TKR_W-1:0]    ticker;
  logic [CLIENT_W-1:0] client;
  logic [PRICE_W-1:0]  limit_price;
  logic [SHARES_W-1:0] share_count;
  modport source (output valid, kind, timestamp, side, ticker, client, limit_price,
                  share_count, input ready);
  modport sink   (input valid, kind, timestamp, side, ticker, client, limit_price,
                  share_count, output ready);
endinterface

interface obme_out_if import obme_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                status;
  logic [TKR_W-1:0]    trade_ticker;
  logic [CLIENT_W-1:0] buyer;
  logic [CLIENT_W-1:0] seller;
  logic [PRICE_W-1:0]  trade_price;
  logic [SHARES_W-1:0] trade_shares;
  logic [VALUE_W-1:0]  trade_value;
  logic [COMM_W-1:0]   commission;
  logic                last;
  modport source (output valid, status, trade_ticker, buyer, seller, trade_price,
                  trade_shares, trade_value, commission, last, input ready);
  modport sink   (input valid, status, trade_ticker, buyer, seller, trade_price,
                  trade_shares, trade_value, commission, last, output ready);
endinterface

// File: hw/rtl/obme_cell.sv
// One book slot: holds an order and updates the probe passing through it.
module obme_cell import obme_pkg::*; #(
  parameter int SLOT       = 0,
  parameter int BOOK_DEPTH = BOOK_DEPTH_DEF,
  parameter bit IS_BUY     = 1'b1
) (
  input  logic   clk,
  input  logic   rst_n,
  input  probe_t prb_in,
  output probe_t prb_out,
  input  upd_t   upd
);

  localparam logic [TKR_W-1:0]  MY_TKR  = TKR_W'(SLOT / BOOK_DEPTH);
  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(SLOT);

  logic                valid_r, valid_nxt;
  logic [PRICE_W-1:0]  price_r, price_nxt;
  logic [SHARES_W-1:0] shares_r, shares_nxt;
  logic [SEQ_W-1:0]    seq_r, seq_nxt;
  logic [CLIENT_W-1:0] client_r, client_nxt;
  probe_t              prb_r, prb_nxt;
  logic                mine, better;

  always_comb begin
    mine = prb_in.vld && (prb_in.tkr == MY_TKR);
    if (price_r != prb_in.price) begin
      better = IS_BUY ? (price_r > prb_in.price) : (price_r < prb_in.price);
    end else begin
      better = seq_r < prb_in.seq;
    end
    prb_nxt    = prb_in;
    valid_nxt  = valid_r;
    price_nxt  = price_r;
    shares_nxt = shares_r;
    seq_nxt    = seq_r;
    client_nxt = client_r;
    if (mine && prb_in.op == OP_BEST && valid_r && (!prb_in.found || better)) begin
      prb_nxt.found  = 1'b1;
      prb_nxt.slot   = MY_SLOT;
      prb_nxt.price  = price_r;
      prb_nxt.shares = shares_r;
      prb_nxt.seq    = seq_r;
      prb_nxt.client = client_r;
    end
    if (mine && prb_in.op == OP_INSERT && !valid_r && !prb_in.found) begin
      prb_nxt.found = 1'b1;
      prb_nxt.slot  = MY_SLOT;
      valid_nxt     = 1'b1;
      price_nxt     = prb_in.price;
      shares_nxt    = prb_in.shares;
      seq_nxt       = prb_in.seq;
      client_nxt    = prb_in.client;
    end
    if (upd.vld && upd.slot == MY_SLOT) begin
      shares_nxt = shares_r - upd.qty;
      if (shares_nxt == '0) begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      prb_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      prb_r   <= prb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    price_r  <= price_nxt;
    shares_r <= shares_nxt;
    seq_r    <= seq_nxt;
    client_r <= client_nxt;
  end

  assign prb_out = prb_r;

endmodule

// File: hw/rtl/obme_div100.sv
// Iterative divide by the commission divisor, four quotient bits per cycle.
module obme_div100 import obme_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [VALUE_W-1:0] dividend,
  output logic               done,
  output logic [VALUE_W-1:0] quotient
);

  localparam int BITS   = 4;
  localparam int STEPS  = VALUE_W / BITS;
  localparam int STEP_W = $clog2(STEPS);
  localparam int REM_W  = 7;
  localparam logic [REM_W:0] DIV = (REM_W+1)'(COMM_DIVISOR);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [STEP_W-1:0]  cnt_r, cnt_nxt;
  logic [VALUE_W-1:0] num_r, num_nxt;
  logic [VALUE_W-1:0] quo_r, quo_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [REM_W:0]     tmp;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    tmp      = '0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = dividend;
      quo_nxt  = '0;
      rem_nxt  = '0;
    end else if (busy_r) begin
      for (int k = 0; k < BITS; k++) begin
        tmp     = {rem_nxt, num_nxt[VALUE_W-1]};
        num_nxt = {num_nxt[VALUE_W-2:0], 1'b0};
        if (tmp >= DIV) begin
          tmp     = tmp - DIV;
          quo_nxt = {quo_nxt[VALUE_W-2:0], 1'b1};
        end else begin
          quo_nxt = {quo_nxt[VALUE_W-2:0], 1'b0};
        end
        rem_nxt = tmp[REM_W-1:0];
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == STEP_W'(STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: hw/rtl/order_book_matching_engine.sv
// Top level of the order book matching engine: controller, cell chains, output stage.
// Usage:
//  in_ch carries order words (kind 0) and end-of-day words (kind 1); one word is
//  taken when the block is idle. out_ch carries trade and reject words; the final
//  word caused by an input word has last set. A word that causes nothing gives
//  no output word.
//  Each side's book is a chain of NT*BOOK_DEPTH cells (NT is TICKERS capped at 4);
//  a probe moves one cell per cycle, so an insert runs through every cell of the chain.
//  A matching pass launches one probe per ticker, collects them at the chain tails,
//  then checks each ticker in turn; a crossed ticker makes a trade through a
//  multiplier stage and an iterative divide by 100.
//  Passes repeat while any ticker traded; at most 64 words per input word.
//  Reset (rst_n low, synchronous) empties both books and clears the stored time
//  and sequence counter. One result waits in a holding register so last can be
//  set; if out_ch stalls, the controller waits before pushing the next word and
//  the next input word is taken once the final word has moved to the output register.
`include "order_book_matching_engine_defines.svh"
module order_book_matching_engine import obme_pkg::*; #(
  parameter int TICKERS    = TICKERS_DEF,
  parameter int BOOK_DEPTH = BOOK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  obme_in_if.sink    in_ch,
  obme_out_if.source out_ch
);

  localparam int NT    = (TICKERS < (1 << TKR_W)) ? TICKERS : (1 << TKR_W);
  localparam int NT_W  = (NT > 1) ? $clog2(NT) : 1;
  localparam int NCELL = NT * BOOK_DEPTH;

  state_t              state_r, state_nxt;
  logic [TS_W-1:0]     cur_time_r, cur_time_nxt;
  logic [SEQ_W-1:0]    order_seq_r, order_seq_nxt;
  logic                do_match_r, do_match_nxt;
  logic                in_side_r, in_side_nxt;
  logic [TKR_W-1:0]    in_tkr_r, in_tkr_nxt;
  logic [CLIENT_W-1:0] in_client_r, in_client_nxt;
  logic                rej_r, rej_nxt;
  logic [TKR_W-1:0]    launch_r, launch_nxt;
  logic [TKR_W-1:0]    arr_r, arr_nxt;
  logic [TKR_W-1:0]    tk_r, tk_nxt;
  logic                traded_r, traded_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  result_t             pend_r, pend_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  result_t             out_r, out_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_vld_r, out_vld_nxt;
  probe_t              res_buy_r [NT];
  probe_t              res_sell_r [NT];
  logic [PRICE_W-1:0]  tprice_r, tprice_nxt;
  logic [SHARES_W-1:0] tqty_r, tqty_nxt;
  logic [CLIENT_W-1:0] tbuyer_r, tbuyer_nxt;
  logic [CLIENT_W-1:0] tseller_r, tseller_nxt;
  logic [VALUE_W-1:0]  value_r;

  probe_t buy_prb [NCELL+1];
  probe_t sell_prb [NCELL+1];
  probe_t buy_tail, sell_tail, rb, rs;
  upd_t   buy_upd, sell_upd;
  logic   accept, in_range, can_push, push, div_start, div_done;
  logic [VALUE_W-1:0] div_q;
  result_t new_res;
  state_t  after_tkr;

  assign accept   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_range = (32'(in_ch.ticker) < 32'(NT));
  assign buy_tail  = buy_prb[NCELL];
  assign sell_tail = sell_prb[NCELL];
  assign rb = res_buy_r[tk_r[NT_W-1:0]];
  assign rs = res_sell_r[tk_r[NT_W-1:0]];
  assign can_push  = !pend_vld_r || !out_vld_r || out_ch.ready;
  assign div_start = (state_r == ST_DSTART);

  for (genvar i = 0; i < NCELL; i++) begin : g_cells
    obme_cell #(.SLOT(i), .BOOK_DEPTH(BOOK_DEPTH), .IS_BUY(1'b1)) u_buy (
      .clk(clk), .rst_n(rst_n), .prb_in(buy_prb[i]), .prb_out(buy_prb[i+1]),
      .upd(buy_upd)
    );
    obme_cell #(.SLOT(i), .BOOK_DEPTH(BOOK_DEPTH), .IS_BUY(1'b0)) u_sell (
      .clk(clk), .rst_n(rst_n), .prb_in(sell_prb[i]), .prb_out(sell_prb[i+1]),
      .upd(sell_upd)
    );
  end

  obme_div100 u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(value_r),
    .done(div_done), .quotient(div_q)
  );

  always_comb begin
    buy_prb[0]  = '0;
    sell_prb[0] = '0;
    buy_upd     = '0;
    sell_upd    = '0;
    if (accept && in_ch.kind != KIND_EOD && in_range) begin
      buy_prb[0].vld    = (in_ch.side == SIDE_BUY);
      buy_prb[0].op     = OP_INSERT;
      buy_prb[0].tkr    = in_ch.ticker;
      buy_prb[0].price  = in_ch.limit_price;
      buy_prb[0].shares = in_ch.share_count;
      buy_prb[0].seq    = order_seq_r;
      buy_prb[0].client = in_ch.client;
      sell_prb[0]       = buy_prb[0];
      sell_prb[0].vld   = (in_ch.side != SIDE_BUY);
    end
    if (state_r == ST_LAUNCH) begin
      buy_prb[0].vld  = 1'b1;
      buy_prb[0].op   = OP_BEST;
      buy_prb[0].tkr  = launch_r;
      sell_prb[0]     = buy_prb[0];
    end
    if (state_r == ST_MUL) begin
      buy_upd.vld  = 1'b1;
      buy_upd.slot = rb.slot;
      buy_upd.qty  = tqty_r;
      sell_upd.vld  = 1'b1;
      sell_upd.slot = rs.slot;
      sell_upd.qty  = tqty_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cur_time_nxt  = cur_time_r;
    order_seq_nxt = order_seq_r;
    do_match_nxt  = do_match_r;
    in_side_nxt   = in_side_r;
    in_tkr_nxt    = in_tkr_r;
    in_client_nxt = in_client_r;
    rej_nxt       = rej_r;
    launch_nxt    = launch_r;
    arr_nxt       = arr_r;
    tk_nxt        = tk_r;
    traded_nxt    = traded_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    pend_vld_nxt  = pend_vld_r;
    out_nxt       = out_r;
    out_last_nxt  = out_last_r;
    out_vld_nxt   = out_vld_r && !out_ch.ready;
    tprice_nxt    = tprice_r;
    tqty_nxt      = tqty_r;
    tbuyer_nxt    = tbuyer_r;
    tseller_nxt   = tseller_r;
    push          = 1'b0;
    new_res       = '0;

    if (tk_r == TKR_W'(NT - 1)) begin
      after_tkr = (traded_r || state_r == ST_EMIT) ? ST_LAUNCH : ST_FIN;
    end else begin
      after_tkr = ST_SEL;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cnt_nxt = '0;
          if (in_ch.kind == KIND_EOD) begin
            state_nxt = ST_LAUNCH;
          end else begin
            order_seq_nxt = order_seq_r + 1'b1;
            do_match_nxt  = (in_ch.timestamp != cur_time_r);
            cur_time_nxt  = in_ch.timestamp;
            in_side_nxt   = in_ch.side;
            in_tkr_nxt    = in_ch.ticker;
            in_client_nxt = in_ch.client;
            if (in_range) begin
              state_nxt = ST_INS;
            end else if (in_ch.timestamp != cur_time_r) begin
              state_nxt = ST_LAUNCH;
            end else begin
              state_nxt = ST_FIN;
            end
          end
          launch_nxt = '0;
          traded_nxt = 1'b0;
        end
      end
      ST_INS: begin
        if (buy_tail.vld || sell_tail.vld) begin
          rej_nxt   = (in_side_r == SIDE_BUY) ? !buy_tail.found : !sell_tail.found;
          state_nxt = ST_REJ;
        end
      end
      ST_REJ: begin
        new_res.status = STAT_REJECT;
        new_res.tkr    = in_tkr_r;
        new_res.buyer  = (in_side_r == SIDE_BUY) ? in_client_r : '0;
        new_res.seller = (in_side_r == SIDE_BUY) ? '0 : in_client_r;
        if (!rej_r || can_push) begin
          push      = rej_r;
          state_nxt = do_match_r ? ST_LAUNCH : ST_FIN;
        end
      end
      ST_LAUNCH: begin
        launch_nxt = launch_r + 1'b1;
        traded_nxt = 1'b0;
        if (launch_r == TKR_W'(NT - 1)) begin
          arr_nxt   = '0;
          state_nxt = ST_COLLECT;
        end
      end
      ST_COLLECT: begin
        if (buy_tail.vld) begin
          arr_nxt = arr_r + 1'b1;
          if (arr_r == TKR_W'(NT - 1)) begin
            tk_nxt    = '0;
            launch_nxt = '0;
            state_nxt = ST_SEL;
          end
        end
      end
      ST_SEL: begin
        if (cnt_r >= CNT_W'(MAX_RESULTS)) begin
          state_nxt = ST_FIN;
        end else if (rb.found && rs.found && rs.price <= rb.price) begin
          tprice_nxt  = (rb.seq < rs.seq) ? rb.price : rs.price;
          tqty_nxt    = (rb.shares < rs.shares) ? rb.shares : rs.shares;
          tbuyer_nxt  = rb.client;
          tseller_nxt = rs.client;
          state_nxt   = ST_MUL;
        end else begin
          state_nxt = after_tkr;
          tk_nxt    = tk_r + 1'b1;
        end
      end
      ST_MUL: begin
        traded_nxt = 1'b1;
        state_nxt  = ST_DSTART;
      end
      ST_DSTART: begin
        state_nxt = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        new_res.status = STAT_TRADE;
        new_res.tkr    = tk_r;
        new_res.buyer  = tbuyer_r;
        new_res.seller = tseller_r;
        new_res.price  = tprice_r;
        new_res.shares = tqty_r;
        new_res.value  = value_r;
        new_res.comm   = COMM_W'(div_q * COMM_MULT);
        if (can_push) begin
          push      = 1'b1;
          state_nxt = after_tkr;
          tk_nxt    = tk_r + 1'b1;
        end
      end
      ST_FIN: begin
        if (!pend_vld_r) begin
          state_nxt = ST_IDLE;
        end else if (!out_vld_r || out_ch.ready) begin
          out_nxt      = pend_r;
          out_last_nxt = 1'b1;
          out_vld_nxt  = 1'b1;
          pend_vld_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (push) begin
      if (pend_vld_r) begin
        out_nxt      = pend_r;
        out_last_nxt = 1'b0;
        out_vld_nxt  = 1'b1;
      end
      pend_nxt     = new_res;
      pend_vld_nxt = 1'b1;
      cnt_nxt      = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_time_r  <= '0;
      order_seq_r <= '0;
      pend_vld_r  <= 1'b0;
      out_vld_r   <= 1'b0;
      cnt_r       <= '0;
      traded_r    <= 1'b0;
      launch_r    <= '0;
      arr_r       <= '0;
      tk_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      cur_time_r  <= cur_time_nxt;
      order_seq_r <= order_seq_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_vld_r   <= out_vld_nxt;
      cnt_r       <= cnt_nxt;
      traded_r    <= traded_nxt;
      launch_r    <= launch_nxt;
      arr_r       <= arr_nxt;
      tk_r        <= tk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    do_match_r  <= do_match_nxt;
    in_side_r   <= in_side_nxt;
    in_tkr_r    <= in_tkr_nxt;
    in_client_r <= in_client_nxt;
    rej_r       <= rej_nxt;
    pend_r      <= pend_nxt;
    out_r       <= out_nxt;
    out_last_r  <= out_last_nxt;
    tprice_r    <= tprice_nxt;
    tqty_r      <= tqty_nxt;
    tbuyer_r    <= tbuyer_nxt;
    tseller_r   <= tseller_nxt;
    value_r     <= VALUE_W'(tprice_r * tqty_r);
    if (state_r == ST_COLLECT && buy_tail.vld) begin
      res_buy_r[buy_tail.tkr[NT_W-1:0]]   <= buy_tail;
      res_sell_r[sell_tail.tkr[NT_W-1:0]] <= sell_tail;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.status       = out_r.status;
  assign out_ch.trade_ticker = out_r.tkr;
  assign out_ch.buyer        = out_r.buyer;
  assign out_ch.seller       = out_r.seller;
  assign out_ch.trade_price  = out_r.price;
  assign out_ch.trade_shares = out_r.shares;
  assign out_ch.trade_value  = out_r.value;
  assign out_ch.commission   = out_r.comm;
  assign out_ch.last         = out_last_r;

  `OBME_ASSERT_NEXT(a_busy_after_accept, accept, state_r != ST_IDLE, "idle after accept")
  `OBME_ASSERT_NOW(a_cnt_limit, 1'b1, cnt_r <= CNT_W'(MAX_RESULTS), "result count over limit")
  `OBME_ASSERT_NOW(a_idle_no_pend, state_r == ST_IDLE, !pend_vld_r, "held result in idle")
  `OBME_ASSERT_NOW(a_chains_aligned, state_r == ST_COLLECT && buy_tail.vld, sell_tail.vld,
                   "probe chains out of step")

endmodule
